/* sv/lr_pkg.sv */
package lr_pkg;

    // coordinate and derived widths
    localparam int COORD_WIDTH = 16;
    localparam int DELTA_W     = COORD_WIDTH + 1;
    localparam int ERR_W       = COORD_WIDTH + 2;
    localparam int SCREEN_W    = 12;
    localparam int LEN_W       = 13;
    localparam int COLOR_W     = 8;

    // configuration register indexes and reset values
    localparam logic [0:0] CFG_SCREEN_MAX_X = 1'b0;
    localparam logic [0:0] CFG_SCREEN_MAX_Y = 1'b1;
    localparam logic [SCREEN_W-1:0] SCREEN_MAX_X_RST = SCREEN_W'(238);
    localparam logic [SCREEN_W-1:0] SCREEN_MAX_Y_RST = SCREEN_W'(79);

    typedef enum logic [0:0] {
        OP_BEGIN = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_HSPAN = 2'd1,
        KIND_VSPAN = 2'd2
    } kind_t;

    typedef struct packed {
        op_t                           op;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic [COLOR_W-1:0]            pen_color;
    } item_t;

    typedef struct packed {
        kind_t                         kind;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic [LEN_W-1:0]              span_length;
        logic [COLOR_W-1:0]            color;
        logic                          last;
    } result_t;

endpackage

/* sv/line_rasterizer.sv */
// line_rasterizer: span and bresenham line engine
// pipeline: one input register then one result register between input beat and result
// throughput: one input beat per cycle while the result side does not stall; each step is one add, compare and subtract
// beats that give no result (rejected spans, idle steps) still take one slot
// reset (rst_n, async low): no line active, pipeline empty, limits back to 238 and 79
module line_rasterizer
    import lr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic [COLOR_W-1:0]            pen_color,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    kind,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic [LEN_W-1:0]              span_length,
    output logic [COLOR_W-1:0]            out_color,
    output logic                          last,
    input  logic                          cfg_write,
    input  logic [0:0]                    cfg_index,
    input  logic [SCREEN_W-1:0]           cfg_data
);

    logic [SCREEN_W-1:0] max_x_reg;
    logic [SCREEN_W-1:0] max_y_reg;
    item_t               item_reg;
    logic                item_valid_reg;
    result_t             out_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                res_valid;
    result_t             res;

    // pipeline control
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= SCREEN_MAX_X_RST;
            max_y_reg <= SCREEN_MAX_Y_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SCREEN_MAX_X: max_x_reg <= cfg_data;
                CFG_SCREEN_MAX_Y: max_y_reg <= cfg_data;
                default:          max_x_reg <= max_x_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.op        <= op_t'(op);
            item_reg.start_x   <= start_x;
            item_reg.start_y   <= start_y;
            item_reg.end_x     <= end_x;
            item_reg.end_y     <= end_y;
            item_reg.pen_color <= pen_color;
        end
    end

    lr_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item         (item_reg),
        .screen_max_x (max_x_reg),
        .screen_max_y (max_y_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    // result beat
    assign out_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign out_x       = out_reg.x;
    assign out_y       = out_reg.y;
    assign span_length = out_reg.span_length;
    assign out_color   = out_reg.color;
    assign last        = out_reg.last;

endmodule

/* sv/lr_engine.sv */
module lr_engine
    import lr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  item_t               item,
    input  logic [SCREEN_W-1:0] screen_max_x,
    input  logic [SCREEN_W-1:0] screen_max_y,
    output logic                res_valid,
    output result_t             res
);

    // line state
    logic signed [COORD_WIDTH-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_WIDTH-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_WIDTH-1:0] stop_reg, stop_next;
    logic [DELTA_W-1:0]            dmaj_reg, dmaj_next;
    logic [DELTA_W-1:0]            dmin_reg, dmin_next;
    logic signed [ERR_W-1:0]       err_reg, err_next;
    logic                          y_major_reg, y_major_next;
    logic                          y_desc_reg, y_desc_next;
    logic                          active_reg, active_next;
    logic [COLOR_W-1:0]            color_reg, color_next;

    // begin path signals
    logic signed [DELTA_W-1:0] sx, sy, ex, ey, mx, my;
    logic signed [DELTA_W-1:0] vlo, vhi, vlo_c, vhi_c;
    logic signed [DELTA_W-1:0] ax, ay, bx, by, hlo_c, hhi_c;
    logic signed [DELTA_W-1:0] span_len;
    logic [DELTA_W-1:0]        dx, dy, dm;
    logic                      desc;

    // step path signals
    logic signed [ERR_W-1:0]       e_sum;
    logic signed [COORD_WIDTH-1:0] y_stepped;
    logic signed [COORD_WIDTH-1:0] step_x, step_y;
    logic                          done;

    assign sx = {item.start_x[COORD_WIDTH-1], item.start_x};
    assign sy = {item.start_y[COORD_WIDTH-1], item.start_y};
    assign ex = {item.end_x[COORD_WIDTH-1], item.end_x};
    assign ey = {item.end_y[COORD_WIDTH-1], item.end_y};
    assign mx = $signed({{(DELTA_W-SCREEN_W){1'b0}}, screen_max_x});
    assign my = $signed({{(DELTA_W-SCREEN_W){1'b0}}, screen_max_y});

    // vertical span ordering and clipping
    assign vlo   = (ey < sy) ? ey : sy;
    assign vhi   = (ey < sy) ? sy : ey;
    assign vlo_c = (vlo < 0) ? '0 : vlo;
    assign vhi_c = (vhi > my) ? my : vhi;

    // order endpoints so the column rises
    assign ax = (sx > ex) ? ex : sx;
    assign ay = (sx > ex) ? ey : sy;
    assign bx = (sx > ex) ? sx : ex;
    assign by = (sx > ex) ? sy : ey;
    assign hlo_c = (ax < 0) ? '0 : ax;
    assign hhi_c = (bx > mx) ? mx : bx;

    // diagonal setup
    assign dx   = DELTA_W'(bx - ax);
    assign desc = (ay > by);
    assign dy   = desc ? DELTA_W'(ay - by) : DELTA_W'(by - ay);
    assign dm   = (dx >= dy) ? dx : dy;

    // one bresenham step
    assign e_sum     = err_reg + $signed({1'b0, dmin_reg});
    assign y_stepped = y_desc_reg ? (cur_y_reg - COORD_WIDTH'(1))
                                  : (cur_y_reg + COORD_WIDTH'(1));
    assign step_x    = (!y_major_reg || e_sum > 0) ? (cur_x_reg + COORD_WIDTH'(1))
                                                   : cur_x_reg;
    assign step_y    = (y_major_reg || e_sum > 0) ? y_stepped : cur_y_reg;
    assign done      = (!y_major_reg) ? (step_x >= stop_reg)
                     : (y_desc_reg ? (step_y <= stop_reg) : (step_y >= stop_reg));

    // next state and result
    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        stop_next    = stop_reg;
        dmaj_next    = dmaj_reg;
        dmin_next    = dmin_reg;
        err_next     = err_reg;
        y_major_next = y_major_reg;
        y_desc_next  = y_desc_reg;
        active_next  = active_reg;
        color_next   = color_reg;
        span_len     = '0;
        res_valid    = 1'b0;
        res.kind        = KIND_POINT;
        res.x           = cur_x_reg;
        res.y           = cur_y_reg;
        res.span_length = LEN_W'(1);
        res.color       = color_reg;
        res.last        = 1'b0;

        if (item.op == OP_BEGIN)
        begin
            color_next  = item.pen_color;
            active_next = 1'b0;
            res.color   = item.pen_color;
            if (sx == ex)
            begin
                // vertical span
                span_len        = vhi_c - vlo_c + DELTA_W'(1);
                res_valid       = !(sx < 0 || sx > mx || vhi < 0 || vlo > my);
                res.kind        = KIND_VSPAN;
                res.x           = item.start_x;
                res.y           = vlo_c[COORD_WIDTH-1:0];
                res.span_length = span_len[LEN_W-1:0];
                res.last        = 1'b1;
            end
            else if (ay == by)
            begin
                // horizontal span
                span_len        = hhi_c - hlo_c + DELTA_W'(1);
                res_valid       = !(ay < 0 || ay > my || bx < 0 || ax > mx);
                res.kind        = KIND_HSPAN;
                res.x           = hlo_c[COORD_WIDTH-1:0];
                res.y           = ay[COORD_WIDTH-1:0];
                res.span_length = span_len[LEN_W-1:0];
                res.last        = 1'b1;
            end
            else
            begin
                // diagonal line, first point
                cur_x_next   = ax[COORD_WIDTH-1:0];
                cur_y_next   = ay[COORD_WIDTH-1:0];
                y_desc_next  = desc;
                y_major_next = (dx < dy);
                dmaj_next    = dm;
                dmin_next    = (dx >= dy) ? dy : dx;
                stop_next    = (dx >= dy) ? bx[COORD_WIDTH-1:0] : by[COORD_WIDTH-1:0];
                err_next     = $signed({2'b00, dm[DELTA_W-1:1]}) - $signed({1'b0, dm});
                active_next  = 1'b1;
                res_valid    = 1'b1;
                res.x        = ax[COORD_WIDTH-1:0];
                res.y        = ay[COORD_WIDTH-1:0];
            end
        end
        else if (active_reg)
        begin
            cur_x_next  = step_x;
            cur_y_next  = step_y;
            err_next    = (e_sum > 0) ? (e_sum - $signed({1'b0, dmaj_reg})) : e_sum;
            active_next = !done;
            res_valid   = 1'b1;
            res.x       = step_x;
            res.y       = step_y;
            res.last    = done;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            stop_reg    <= '0;
            dmaj_reg    <= '0;
            dmin_reg    <= '0;
            err_reg     <= '0;
            y_major_reg <= 1'b0;
            y_desc_reg  <= 1'b0;
            active_reg  <= 1'b0;
            color_reg   <= '0;
        end
        else if (advance)
        begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            stop_reg    <= stop_next;
            dmaj_reg    <= dmaj_next;
            dmin_reg    <= dmin_next;
            err_reg     <= err_next;
            y_major_reg <= y_major_next;
            y_desc_reg  <= y_desc_next;
            active_reg  <= active_next;
            color_reg   <= color_next;
        end
    end

endmodule

/* tb/sv/line_rasterizer_checker.sv */
`timescale 1ns / 100ps

module line_rasterizer_checker
    import lr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          op,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic [COLOR_W-1:0]            pen_color,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [1:0]                    kind,
    input  logic signed [COORD_WIDTH-1:0] out_x,
    input  logic signed [COORD_WIDTH-1:0] out_y,
    input  logic [LEN_W-1:0]              span_length,
    input  logic [COLOR_W-1:0]            out_color,
    input  logic                          last,
    input  logic                          cfg_write,
    input  logic [0:0]                    cfg_index,
    input  logic [SCREEN_W-1:0]           cfg_data,
    output int                            mismatch_count,
    output int                            pending_count
);

    // line walker state, mirrors what the engine holds between beats
    logic signed [COORD_WIDTH-1:0] pen_x, pen_y, stop_at;
    logic [DELTA_W-1:0]            d_major, d_minor;
    logic signed [ERR_W-1:0]       err_acc;
    logic                          steep, falling, drawing;
    logic [COLOR_W-1:0]            ink;
    logic [SCREEN_W-1:0]           lim_x, lim_y;

    result_t queued_draws[$];
    int      fault_tally;

    // works out the draw command caused by one input beat, if any
    function automatic bit rasterize(input item_t it, output result_t res);
        int x1, y1, x2, y2, swap, mx, my;
        int px, py, stop, err, dmaj, dmin, dx, dy, step_y;
        bit done;
        mx  = int'(lim_x);
        my  = int'(lim_y);
        res = '0;
        res.span_length = LEN_W'(1);

        if (it.op == OP_BEGIN)
        begin
            x1 = int'($signed(it.start_x));
            y1 = int'($signed(it.start_y));
            x2 = int'($signed(it.end_x));
            y2 = int'($signed(it.end_y));
            ink     = it.pen_color;
            drawing = 1'b0;
            res.color = ink;
            res.last  = 1'b1;

            // vertical span, also covers a single point
            if (x1 == x2)
            begin
                if (y2 < y1)
                begin
                    swap = y1; y1 = y2; y2 = swap;
                end
                if (x1 < 0 || x1 > mx || y2 < 0 || y1 > my)
                    return 1'b0;
                if (y1 < 0)
                    y1 = 0;
                if (y2 > my)
                    y2 = my;
                res.kind        = KIND_VSPAN;
                res.x           = COORD_WIDTH'(x1);
                res.y           = COORD_WIDTH'(y1);
                res.span_length = LEN_W'(y2 - y1 + 1);
                return 1'b1;
            end

            // order endpoints so the column rises
            if (x1 > x2)
            begin
                swap = x1; x1 = x2; x2 = swap;
                swap = y1; y1 = y2; y2 = swap;
            end

            // horizontal span
            if (y1 == y2)
            begin
                if (y1 < 0 || y1 > my || x2 < 0 || x1 > mx)
                    return 1'b0;
                if (x1 < 0)
                    x1 = 0;
                if (x2 > mx)
                    x2 = mx;
                res.kind        = KIND_HSPAN;
                res.x           = COORD_WIDTH'(x1);
                res.y           = COORD_WIDTH'(y1);
                res.span_length = LEN_W'(x2 - x1 + 1);
                return 1'b1;
            end

            // diagonal: set up the walk and give the first point
            dx      = x2 - x1;
            dy      = (y1 > y2) ? (y1 - y2) : (y2 - y1);
            falling = (y1 > y2);
            pen_x   = COORD_WIDTH'(x1);
            pen_y   = COORD_WIDTH'(y1);
            if (dx >= dy)
            begin
                steep = 1'b0;
                dmaj  = dx;
                dmin  = dy;
                stop  = x2;
            end
            else
            begin
                steep = 1'b1;
                dmaj  = dy;
                dmin  = dx;
                stop  = y2;
            end
            d_major = DELTA_W'(dmaj);
            d_minor = DELTA_W'(dmin);
            stop_at = COORD_WIDTH'(stop);
            err_acc = ERR_W'((dmaj / 2) - dmaj);
            drawing = 1'b1;
            res.kind = KIND_POINT;
            res.x    = pen_x;
            res.y    = pen_y;
            res.last = 1'b0;
            return 1'b1;
        end

        // step beat
        if (!drawing)
            return 1'b0;
        px     = int'($signed(pen_x));
        py     = int'($signed(pen_y));
        stop   = int'($signed(stop_at));
        err    = int'($signed(err_acc));
        dmaj   = int'(d_major);
        dmin   = int'(d_minor);
        step_y = falling ? -1 : 1;
        if (!steep)
        begin
            px++;
            err += dmin;
            if (err > 0)
            begin
                py  += step_y;
                err -= dmaj;
            end
            done = (px >= stop);
        end
        else
        begin
            py  += step_y;
            err += dmin;
            if (err > 0)
            begin
                px++;
                err -= dmaj;
            end
            done = falling ? (py <= stop) : (py >= stop);
        end
        pen_x   = COORD_WIDTH'(px);
        pen_y   = COORD_WIDTH'(py);
        err_acc = ERR_W'(err);
        if (done)
            drawing = 1'b0;
        res.kind  = KIND_POINT;
        res.x     = pen_x;
        res.y     = pen_y;
        res.color = ink;
        res.last  = done;
        return 1'b1;
    endfunction

    function automatic string draw_text(input result_t r);
        return $sformatf("kind=%0d x=%0d y=%0d len=%0d color=%0d last=%0d",
                         r.kind, $signed(r.x), $signed(r.y), r.span_length, r.color,
                         r.last);
    endfunction

    // count a bad result beat, report only the first few
    task automatic flag_draw(input bit orphan, input result_t want, input result_t got);
        fault_tally++;
        if (fault_tally <= 10)
        begin
            if (orphan)
                $display("%0t: result beat with nothing expected: %s", $time, draw_text(got));
            else
                $display("%0t: mismatch, expected %s, got %s", $time, draw_text(want),
                         draw_text(got));
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t   beat;
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            pen_x   = '0;
            pen_y   = '0;
            stop_at = '0;
            d_major = '0;
            d_minor = '0;
            err_acc = '0;
            steep   = 1'b0;
            falling = 1'b0;
            drawing = 1'b0;
            ink     = '0;
            lim_x   = SCREEN_MAX_X_RST;
            lim_y   = SCREEN_MAX_Y_RST;
            queued_draws.delete();
            fault_tally = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            // screen limit writes
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SCREEN_MAX_X: lim_x = cfg_data;
                    CFG_SCREEN_MAX_Y: lim_y = cfg_data;
                    default: ;
                endcase
            end

            // result beat against oldest expectation
            if (out_valid && !out_stall)
            begin
                got.kind        = kind_t'(kind);
                got.x           = out_x;
                got.y           = out_y;
                got.span_length = span_length;
                got.color       = out_color;
                got.last        = last;
                if (queued_draws.size() == 0)
                begin
                    flag_draw(1'b1, got, got);
                end
                else
                begin
                    want = queued_draws.pop_front();
                    if (got !== want)
                        flag_draw(1'b0, want, got);
                end
            end

            // input beat
            if (in_valid && !in_stall)
            begin
                beat.op        = op_t'(op);
                beat.start_x   = start_x;
                beat.start_y   = start_y;
                beat.end_x     = end_x;
                beat.end_y     = end_y;
                beat.pen_color = pen_color;
                if (rasterize(beat, want))
                    queued_draws.push_back(want);
            end

            mismatch_count <= fault_tally;
            pending_count  <= queued_draws.size();
        end
    end

endmodule

/* tb/sv/tb_line_rasterizer.sv */
`timescale 1ns / 100ps

module tb_line_rasterizer;
    import lr_pkg::*;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          op;
    logic signed [COORD_WIDTH-1:0] start_x, start_y, end_x, end_y;
    logic [COLOR_W-1:0]            pen_color;
    logic                          out_valid;
    logic                          out_stall;
    logic [1:0]                    kind;
    logic signed [COORD_WIDTH-1:0] out_x, out_y;
    logic [LEN_W-1:0]              span_length;
    logic [COLOR_W-1:0]            out_color;
    logic                          last;
    logic                          cfg_write;
    logic [0:0]                    cfg_index;
    logic [SCREEN_W-1:0]           cfg_data;

    int   mismatch_count;
    int   pending_count;
    int   beats_sent;
    int   send_gap_pct;
    int   sink_gap_pct = 38;
    logic hold_request = 1'b0;
    int   scr_x, scr_y;

    always #4 clk = ~clk;

    line_rasterizer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .pen_color   (pen_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_x       (out_x),
        .out_y       (out_y),
        .span_length (span_length),
        .out_color   (out_color),
        .last        (last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    line_rasterizer_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .pen_color      (pen_color),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .out_x          (out_x),
        .out_y          (out_y),
        .span_length    (span_length),
        .out_color      (out_color),
        .last           (last),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    function automatic int rand_coord();
        return int'($signed(16'($urandom())));
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // coordinate biased toward the screen border
    function automatic int near_edge(input int lim);
        int pick;
        pick = $urandom_range(3);
        case (pick)
            0: return rand_coord();
            1: return int'($urandom_range(lim + 16)) - 8;
            2: return ($urandom_range(1) ? lim : 0) + int'($urandom_range(1)) *
                      ($urandom_range(1) ? 1 : -1);
            default: return int'($urandom_range(lim));
        endcase
    endfunction

    // one input beat, held until accepted
    task automatic send_beat(input op_t code, input int sx, input int sy, input int ex,
                             input int ey, input int color);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= code;
        start_x   <= COORD_WIDTH'(sx);
        start_y   <= COORD_WIDTH'(sy);
        end_x     <= COORD_WIDTH'(ex);
        end_y     <= COORD_WIDTH'(ey);
        pen_color <= COLOR_W'(color);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic begin_line(input int sx, input int sy, input int ex, input int ey,
                              input int color);
        send_beat(OP_BEGIN, sx, sy, ex, ey, color);
    endtask

    // step beats carry junk in the unused fields
    task automatic step_line(input int count);
        for (int i = 0; i < count; i++)
            send_beat(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(255));
    endtask

    // let every expected result come out, then a few more cycles
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_limits(input int lx, input int ly);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SCREEN_MAX_X;
        cfg_data  <= SCREEN_W'(lx);
        @(posedge clk);
        cfg_index <= CFG_SCREEN_MAX_Y;
        cfg_data  <= SCREEN_W'(ly);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        scr_x = lx;
        scr_y = ly;
    endtask

    // mostly complete lines with random content, some spans, some noise
    task automatic random_traffic(input int goal);
        int pick, x1, y1, x2, y2, dmaj, dmin, adx, ady, steps, y_sign, x_sign;
        while (beats_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                send_beat(op_t'($urandom_range(1)), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), $urandom_range(255));
            end
            else if (pick < 28)
            begin
                if ($urandom_range(1))
                begin
                    x1 = near_edge(scr_x);
                    begin_line(x1, near_edge(scr_y), x1, near_edge(scr_y),
                               $urandom_range(255));
                end
                else
                begin
                    y1 = near_edge(scr_y);
                    begin_line(near_edge(scr_x), y1, near_edge(scr_x), y1,
                               $urandom_range(255));
                end
                // idle step after a span
                if ($urandom_range(3) == 0)
                    step_line(1);
            end
            else
            begin
                x1 = $urandom_range(1) ? rand_coord() : near_edge(scr_x);
                y1 = $urandom_range(1) ? rand_coord() : near_edge(scr_y);
                dmaj = ($urandom_range(9) == 0) ? $urandom_range(20, 300) :
                                                  $urandom_range(1, 12);
                dmin = $urandom_range(dmaj);
                x_sign = $urandom_range(1) ? 1 : -1;
                y_sign = $urandom_range(1) ? 1 : -1;
                if ($urandom_range(1))
                begin
                    x2 = clamp_coord(x1 + x_sign * dmaj);
                    y2 = clamp_coord(y1 + y_sign * dmin);
                end
                else
                begin
                    x2 = clamp_coord(x1 + x_sign * dmin);
                    y2 = clamp_coord(y1 + y_sign * dmaj);
                end
                adx   = (x2 > x1) ? (x2 - x1) : (x1 - x2);
                ady   = (y2 > y1) ? (y2 - y1) : (y1 - y2);
                steps = (adx > ady) ? adx : ady;
                begin_line(x1, y1, x2, y2, $urandom_range(255));
                // cut short, run past the end, or walk exactly to the end
                pick = $urandom_range(9);
                if (pick == 0)
                    steps = $urandom_range(steps);
                else if (pick == 1)
                    steps = steps + $urandom_range(1, 3);
                step_line(steps);
            end
        end
    endtask

    // receiver: random stall plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < sink_gap_pct);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int goal;
        int lx, ly;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_BEGIN;
        start_x      = '0;
        start_y      = '0;
        end_x        = '0;
        end_y        = '0;
        pen_color    = '0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_SCREEN_MAX_X;
        cfg_data     = '0;
        beats_sent   = 0;
        send_gap_pct = 38;
        scr_x        = 238;
        scr_y        = 79;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset limits
        step_line(1);
        begin_line(10, 20, 10, 5, 8'h00);
        begin_line(238, -5, 238, 100, 8'hFF);
        begin_line(100, -32768, 100, 32767, 8'h5A);
        begin_line(239, 0, 239, 10, 8'h11);
        begin_line(0, 80, 0, 90, 8'h22);
        begin_line(300, 79, -300, 79, 8'hA5);
        begin_line(0, -1, 10, -1, 8'h33);
        begin_line(239, 5, 400, 5, 8'h44);
        begin_line(5, 5, 5, 5, 8'h80);
        begin_line(0, 0, 3, 1, 8'h01);
        step_line(3);
        begin_line(1, 4, 2, 0, 8'h7F);
        step_line(4);
        begin_line(0, 0, 2, 2, 8'hC3);
        step_line(2);
        // widest possible line, dropped by the next begin
        begin_line(-32768, -32768, 32767, 32767, 8'hFE);
        step_line(2);
        begin_line(32767, -32768, 32765, -32767, 8'h3C);
        step_line(3);

        // random part over several screen sizes
        goal = beats_sent;
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    lx = 4095;
                    ly = 4095;
                end
                1:
                begin
                    lx = 0;
                    ly = 0;
                end
                2:
                begin
                    lx = $urandom_range(4095);
                    ly = $urandom_range(4095);
                end
                3:
                begin
                    lx = 4095;
                    ly = 0;
                end
                4:
                begin
                    lx = 0;
                    ly = 4095;
                end
                default:
                begin
                    lx = $urandom_range(300);
                    ly = $urandom_range(300);
                end
            endcase
            set_limits(lx, ly);
            // one stretch with no idling on either side
            send_gap_pct = (ph == 2) ? 0 : 38;
            sink_gap_pct <= (ph == 2) ? 0 : 38;
            if (ph == 3)
                hold_request <= 1'b1;
            goal += 160;
            random_traffic(goal);
        end

        drain();
        if (mismatch_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
